// ===== sv/u8d_pkg.sv =====
// u8d_pkg: shared types, constants and the windows-1252 table for the utf-8 decoder
// no dependencies; compiled first
package u8d_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int PEND_DEPTH  = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD_MIN     = 8'hC2;
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD4_MIN    = 8'hF0;
    localparam logic [7:0] LEAD_MAX     = 8'hF4;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [7:0] LEAD_E0      = 8'hE0;
    localparam logic [7:0] LEAD_F0      = 8'hF0;
    localparam logic [7:0] LEAD_F4      = 8'hF4;
    localparam logic [7:0] E0_CONT_MIN  = 8'hA0;
    localparam logic [7:0] F0_CONT_MIN  = 8'h90;
    localparam logic [7:0] F4_CONT_MAX  = 8'h8F;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_ONE  = 3'd1;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
        logic        end_marker;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [PEND_DEPTH-1:0][7:0] pend;
        logic [1:0]                 count;
        logic [2:0]                 seq_len;
    } dec_state_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] results;
        logic [2:0]                num;
        dec_state_t                state_next;
    } step_t;

    // windows-1252 code point for one byte; 80-9f remapped, others map to themselves
    function automatic logic [20:0] win_map(input logic [7:0] b);
        logic [15:0] cp;
        cp = {8'h00, b};
        if (b[7:5] == 3'b100)
        begin
            unique case (b[4:0])
                5'h00: cp = 16'h20AC;
                5'h01: cp = 16'h0081;
                5'h02: cp = 16'h201A;
                5'h03: cp = 16'h0192;
                5'h04: cp = 16'h201E;
                5'h05: cp = 16'h2026;
                5'h06: cp = 16'h2020;
                5'h07: cp = 16'h2021;
                5'h08: cp = 16'h02C6;
                5'h09: cp = 16'h2030;
                5'h0A: cp = 16'h0160;
                5'h0B: cp = 16'h2039;
                5'h0C: cp = 16'h0152;
                5'h0D: cp = 16'h008D;
                5'h0E: cp = 16'h017D;
                5'h0F: cp = 16'h008F;
                5'h10: cp = 16'h0090;
                5'h11: cp = 16'h2018;
                5'h12: cp = 16'h2019;
                5'h13: cp = 16'h201C;
                5'h14: cp = 16'h201D;
                5'h15: cp = 16'h2022;
                5'h16: cp = 16'h2013;
                5'h17: cp = 16'h2014;
                5'h18: cp = 16'h02DC;
                5'h19: cp = 16'h2122;
                5'h1A: cp = 16'h0161;
                5'h1B: cp = 16'h203A;
                5'h1C: cp = 16'h0153;
                5'h1D: cp = 16'h009D;
                5'h1E: cp = 16'h017E;
                5'h1F: cp = 16'h0178;
                default: cp = {8'h00, b};
            endcase
        end
        return {5'b0, cp};
    endfunction

endpackage

// ===== sv/u8d_if.sv =====
// u8d_byte_if and u8d_cp_if: valid/ready channels for raw bytes and decoded results
// no dependencies; compiled after u8d_pkg
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  bytes_used;
    logic        end_marker;
    logic        last_of_run;

    modport source (output valid, output code_point, output bytes_used,
                    output end_marker, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input bytes_used,
                    input end_marker, input last_of_run, output ready);
endinterface

// ===== sv/utf8_decoder_cp1252_fallback_core.sv =====
// utf8_decoder_cp1252_fallback_core: utf-8 byte stream to code points, cp1252 fallback
// depends on u8d_pkg, u8d_if (u8d_byte_if, u8d_cp_if) and u8d_step
//
// usage
//   byte_stream carries one request per raw byte (data_byte) or an end request
//   (end_of_stream set, data_byte ignored). code_points carries decoded results:
//   code_point, bytes_used, end_marker and last_of_run on the final result of a request
// flow
//   one byte is accepted per cycle while byte_stream.ready is high; its results
//   show on code_points in order, one result per cycle while code_points.ready is
//   high. a byte yields 0 to 4 results; a broken sequence or an end request also emits the held bytes
// structure
//   the decode step is combinational between the sequence state registers and an
//   8-entry result queue; all results of a request are written to the queue at once
// stalls
//   byte_stream.ready is high while the queue has room for a full burst of 4
//   results; a stalled receiver fills the queue and then holds off new bytes
// reset
//   rst_n clears the open sequence and empties the queue; no results are lost or
//   repeated across stalls
module utf8_decoder_cp1252_fallback_core (
    input  logic             clk,
    input  logic             rst_n,
    u8d_byte_if.sink         byte_stream,
    u8d_cp_if.source         code_points
);
    import u8d_pkg::*;

    // open sequence: buffered bytes carry no reset, only entries below count are read
    logic [PEND_DEPTH-1:0][7:0] pend_reg;
    logic [1:0]                 count_reg;
    logic [2:0]                 seq_len_reg;
    dec_state_t                 state_cur;
    step_t                      step;

    // result queue
    result_t                    fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]         wr_ptr_reg;
    logic [FIFO_AW-1:0]         wr_ptr_next;
    logic [FIFO_AW-1:0]         rd_ptr_reg;
    logic [FIFO_AW-1:0]         rd_ptr_next;
    logic [FIFO_CW-1:0]         fill_reg;
    logic [FIFO_CW-1:0]         fill_next;

    logic                       in_fire;
    logic                       out_fire;
    result_t                    head;

    assign state_cur.pend    = pend_reg;
    assign state_cur.count   = count_reg;
    assign state_cur.seq_len = seq_len_reg;

    u8d_step u_step (
        .data_byte     (byte_stream.data_byte),
        .end_of_stream (byte_stream.end_of_stream),
        .state_cur     (state_cur),
        .step          (step)
    );

    // room for a whole burst of results
    assign byte_stream.ready = (fill_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));
    assign in_fire           = byte_stream.valid && byte_stream.ready;
    assign out_fire          = code_points.valid && code_points.ready;

    assign wr_ptr_next = in_fire ? wr_ptr_reg + FIFO_AW'(step.num) : wr_ptr_reg;
    assign rd_ptr_next = out_fire ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
    assign fill_next   = fill_reg
                         + (in_fire ? FIFO_CW'(step.num) : FIFO_CW'(0))
                         - (out_fire ? FIFO_CW'(1) : FIFO_CW'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 2'd0;
            seq_len_reg <= SEQ_NONE;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg   <= step.state_next.count;
                seq_len_reg <= step.state_next.seq_len;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_reg <= step.state_next.pend;
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                if (3'(k) < step.num)
                    fifo_reg[wr_ptr_reg + FIFO_AW'(k)] <= step.results[k];
            end
        end
    end

    assign head = fifo_reg[rd_ptr_reg];

    assign code_points.valid       = (fill_reg != '0);
    assign code_points.code_point  = head.code_point;
    assign code_points.bytes_used  = head.bytes_used;
    assign code_points.end_marker  = head.end_marker;
    assign code_points.last_of_run = head.last_of_run;

endmodule

// ===== sv/u8d_step.sv =====
// u8d_step: combinational decode of one byte against the open sequence state
// depends on u8d_pkg
module u8d_step (
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    input  u8d_pkg::dec_state_t state_cur,
    output u8d_pkg::step_t      step
);
    import u8d_pkg::*;

    logic        flush;
    logic        do_start;
    logic        tail_valid;
    result_t     tail;
    logic        cont_ok;
    logic [20:0] assembled;
    logic [2:0]  num_flush;
    logic [2:0]  num;
    dec_state_t  nxt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;

    assign b0 = state_cur.pend[0];
    assign b1 = state_cur.pend[1];
    assign b2 = state_cur.pend[2];

    always_comb
    begin
        cont_ok = ((data_byte & CONT_MASK) == CONT_TAG);
        if (state_cur.count == 2'd1)
        begin
            if (b0 == LEAD_E0 && data_byte < E0_CONT_MIN) cont_ok = 1'b0;
            if (b0 == LEAD_F0 && data_byte < F0_CONT_MIN) cont_ok = 1'b0;
            if (b0 == LEAD_F4 && data_byte > F4_CONT_MAX) cont_ok = 1'b0;
        end
    end

    // bytes are already validated, so masking equals the offset subtraction
    always_comb
    begin
        case (state_cur.seq_len)
            SEQ_TWO:   assembled = {10'b0, b0[4:0], data_byte[5:0]};
            SEQ_THREE: assembled = {5'b0, b0[3:0], b1[5:0], data_byte[5:0]};
            SEQ_FOUR:  assembled = {b0[2:0], b1[5:0], b2[5:0], data_byte[5:0]};
            default:   assembled = '0;
        endcase
    end

    always_comb
    begin
        flush      = 1'b0;
        do_start   = 1'b0;
        tail_valid = 1'b0;
        tail       = '0;
        nxt        = state_cur;

        if (end_of_stream)
        begin
            flush           = 1'b1;
            tail_valid      = 1'b1;
            tail.end_marker = 1'b1;
            nxt.count       = 2'd0;
            nxt.seq_len     = SEQ_NONE;
        end
        else if (state_cur.count == 2'd0)
        begin
            do_start = 1'b1;
        end
        else if (cont_ok)
        begin
            if ({1'b0, state_cur.count} + 3'd1 == state_cur.seq_len)
            begin
                tail_valid      = 1'b1;
                tail.code_point = assembled;
                tail.bytes_used = state_cur.seq_len;
                nxt.count       = 2'd0;
                nxt.seq_len     = SEQ_NONE;
            end
            else
            begin
                nxt.pend[state_cur.count] = data_byte;
                nxt.count                 = state_cur.count + 2'd1;
            end
        end
        else
        begin
            flush       = 1'b1;
            do_start    = 1'b1;
            nxt.count   = 2'd0;
            nxt.seq_len = SEQ_NONE;
        end

        if (do_start)
        begin
            if (data_byte < ASCII_LIMIT)
            begin
                tail_valid      = 1'b1;
                tail.code_point = {13'b0, data_byte};
                tail.bytes_used = SEQ_ONE;
            end
            else if (data_byte >= LEAD_MIN && data_byte <= LEAD_MAX)
            begin
                nxt.pend[0] = data_byte;
                nxt.count   = 2'd1;
                if (data_byte < LEAD3_MIN)
                    nxt.seq_len = SEQ_TWO;
                else if (data_byte < LEAD4_MIN)
                    nxt.seq_len = SEQ_THREE;
                else
                    nxt.seq_len = SEQ_FOUR;
            end
            else
            begin
                tail_valid      = 1'b1;
                tail.code_point = win_map(data_byte);
                tail.bytes_used = SEQ_ONE;
            end
        end
    end

    assign num_flush = flush ? {1'b0, state_cur.count} : 3'd0;
    assign num       = num_flush + {2'b0, tail_valid};

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (3'(i) < num_flush)
            begin
                step.results[i].code_point = win_map(state_cur.pend[2'(i % PEND_DEPTH)]);
                step.results[i].bytes_used = SEQ_ONE;
                step.results[i].end_marker = 1'b0;
            end
            else
            begin
                step.results[i].code_point = tail.code_point;
                step.results[i].bytes_used = tail.bytes_used;
                step.results[i].end_marker = tail.end_marker;
            end
            step.results[i].last_of_run = (3'(i) + 3'd1 == num);
        end
        step.num        = num;
        step.state_next = nxt;
    end

endmodule

// ===== dv/utf8_decoder_cp1252_fallback_core_test.sv =====
// utf8_decoder_cp1252_fallback_core_test: byte stream stimulus, cycle-free decode prediction
// and in-order result checking; depends on u8d_pkg and u8d_if (u8d_byte_if, u8d_cp_if)
// a directed table runs first, then random utf-8 text with broken sequences and noise
module utf8_decoder_cp1252_fallback_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    // one request on the byte channel; typed rows carry their result written out by hand
    typedef struct {
        logic [7:0]  data;
        logic        eos;
        bit          typed;
        bit          has_res;
        logic [20:0] cp;
        logic [2:0]  used;
        logic        endm;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    u8d_byte_if bytes_if ();
    u8d_cp_if   cps_if ();

    utf8_decoder_cp1252_fallback_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (bytes_if),
        .code_points (cps_if)
    );

    always #6 clk = ~clk;

    // windows-1252 code points for bytes 80-9f; every other byte stands for itself
    logic [20:0] cp1252_hi [32] = '{
        21'h20AC, 21'h0081, 21'h201A, 21'h0192, 21'h201E, 21'h2026, 21'h2020, 21'h2021,
        21'h02C6, 21'h2030, 21'h0160, 21'h2039, 21'h0152, 21'h008D, 21'h017D, 21'h008F,
        21'h0090, 21'h2018, 21'h2019, 21'h201C, 21'h201D, 21'h2022, 21'h2013, 21'h2014,
        21'h02DC, 21'h2122, 21'h0161, 21'h203A, 21'h0153, 21'h009D, 21'h017E, 21'h0178
    };

    // directed requests: extremes, stray and invalid leads, overlong and range
    // breaks after e0, f0 and f4, the surrogate range after ed, end with and
    // without buffered bytes
    stim_row_t directed [26] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 21'h000000, 3'd1, 1'b0},  // ascii low end
        '{8'h7F, 1'b0, 1'b1, 1'b1, 21'h00007F, 3'd1, 1'b0},  // ascii high end
        '{8'h80, 1'b0, 1'b1, 1'b1, 21'h0020AC, 3'd1, 1'b0},  // stray continuation
        '{8'hC0, 1'b0, 1'b1, 1'b1, 21'h0000C0, 3'd1, 1'b0},  // invalid lead
        '{8'hC1, 1'b0, 1'b1, 1'b1, 21'h0000C1, 3'd1, 1'b0},
        '{8'hF5, 1'b0, 1'b1, 1'b1, 21'h0000F5, 3'd1, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 21'h0000FF, 3'd1, 1'b0},
        '{8'hC2, 1'b0, 1'b1, 1'b0, 21'h000000, 3'd0, 1'b0},  // lowest 2-byte lead, buffered
        '{8'h80, 1'b0, 1'b1, 1'b1, 21'h000080, 3'd2, 1'b0},
        '{8'hE0, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'h9F, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},  // overlong after e0
        '{8'hED, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},  // surrogate kept
        '{8'h80, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},  // overlong after f0
        '{8'hF4, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'hBF, 1'b0, 1'b1, 1'b1, 21'h10FFFF, 3'd4, 1'b0},  // highest scalar value
        '{8'hF4, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'h90, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},  // above range after f4
        '{8'hE2, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'h82, 1'b0, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},
        '{8'h5A, 1'b1, 1'b0, 1'b0, 21'h000000, 3'd0, 1'b0},  // end flushes e2 82
        '{8'hA5, 1'b1, 1'b1, 1'b1, 21'h000000, 3'd0, 1'b1}   // end with nothing held
    };

    stim_row_t stim [$];
    result_t   awaited_cps [$];    // results still owed by the block, oldest first
    result_t   step_out [$];       // results of the request being decoded

    // decoder state as the predictor sees it
    logic [7:0] held [3];
    int         held_cnt = 0;
    int         seq_len  = 0;

    bit calm = 1'b0;               // no gaps on either side while set
    int errors = 0;
    int n_requests = 0, n_results = 0, n_multi = 0, n_fallback = 0, n_ends = 0;

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    function automatic logic [20:0] cp1252(input logic [7:0] b);
        return (b[7:5] == 3'b100) ? cp1252_hi[b[4:0]] : {13'd0, b};
    endfunction

    function automatic void emit(input logic [20:0] cp, input logic [2:0] used,
                                 input logic endm);
        result_t r;
        r.code_point  = cp;
        r.bytes_used  = used;
        r.end_marker  = endm;
        r.last_of_run = 1'b0;
        step_out.push_back(r);
    endfunction

    // every held byte goes out on its own under the code page
    function automatic void flush_held();
        for (int i = 0; i < held_cnt; i++)
            emit(cp1252(held[i]), 3'd1, 1'b0);
        held_cnt = 0;
        seq_len  = 0;
    endfunction

    // byte seen with nothing held: ascii, a lead that opens a sequence, or fallback
    function automatic void open_or_pass(input logic [7:0] b);
        if (b < 8'h80)
            emit({13'd0, b}, 3'd1, 1'b0);
        else if (b >= 8'hC2 && b <= 8'hF4)
        begin
            held[0]  = b;
            held_cnt = 1;
            seq_len  = (b < 8'hE0) ? 2 : (b < 8'hF0) ? 3 : 4;
        end
        else
            emit(cp1252(b), 3'd1, 1'b0);
    endfunction

    // range limits apply to the first continuation only
    function automatic bit continues(input logic [7:0] b);
        if (b[7:6] != 2'b10)
            return 1'b0;
        if (held_cnt == 1)
        begin
            if (held[0] == 8'hE0 && b < 8'hA0) return 1'b0;
            if (held[0] == 8'hF0 && b < 8'h90) return 1'b0;
            if (held[0] == 8'hF4 && b > 8'h8F) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        int unsigned acc;
        step_out.delete();
        if (eos)
        begin
            flush_held();
            emit(21'd0, 3'd0, 1'b1);
        end
        else if (held_cnt == 0)
            open_or_pass(b);
        else if (continues(b))
        begin
            if (held_cnt + 1 == seq_len)
            begin
                acc = held[0];
                for (int i = 1; i < held_cnt; i++)
                    acc = (acc << 6) + held[i];
                acc = (acc << 6) + b;
                case (seq_len)
                    2:       acc = acc - 32'h3080;
                    3:       acc = acc - 32'hE2080;
                    default: acc = acc - 32'h3C82080;
                endcase
                emit(acc[20:0], seq_len[2:0], 1'b0);
                held_cnt = 0;
                seq_len  = 0;
            end
            else
            begin
                held[held_cnt] = b;
                held_cnt++;
            end
        end
        else
        begin
            // broken sequence: flush, then the offending byte starts afresh
            flush_held();
            open_or_pass(b);
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last_of_run = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus planning
    // ---------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b, input logic eos);
        stim_row_t r;
        r = '{b, eos, 1'b0, 1'b0, 21'd0, 3'd0, 1'b0};
        stim.push_back(r);
    endfunction

    // mostly well-formed utf-8 with random content; some sequences cut short and
    // followed by an arbitrary byte or an end request, plus raw noise
    task automatic plan_random_text(input int n_items);
        int         pick, len, keep, start;
        logic [7:0] s [4];
        start = stim.size();
        while (stim.size() - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
                add_byte(8'($urandom_range(0, 127)), 1'b0);
            else if (pick < 80)
            begin
                len = $urandom_range(2, 4);
                case (len)
                    2:       s[0] = 8'($urandom_range(8'hC2, 8'hDF));
                    3:       s[0] = 8'($urandom_range(8'hE0, 8'hEF));
                    default: s[0] = 8'($urandom_range(8'hF0, 8'hF4));
                endcase
                for (int i = 1; i < 4; i++)
                    s[i] = 8'($urandom_range(8'h80, 8'hBF));
                if (s[0] == 8'hE0) s[1] = 8'($urandom_range(8'hA0, 8'hBF));
                if (s[0] == 8'hF0) s[1] = 8'($urandom_range(8'h90, 8'hBF));
                if (s[0] == 8'hF4) s[1] = 8'($urandom_range(8'h80, 8'h8F));
                keep = (pick < 68) ? len : $urandom_range(1, len - 1);
                for (int i = 0; i < keep; i++)
                    add_byte(s[i], 1'b0);
                if (keep < len)
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            end
            else if (pick < 94)
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            else
                add_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92)         return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---------------------------------------------------------------------
    // request side: drive at the falling edge, accept at the rising edge
    // ---------------------------------------------------------------------

    initial
    begin
        stim_row_t row;
        int        gap;
        rst_n                  = 1'b0;
        bytes_if.valid         = 1'b0;
        bytes_if.data_byte     = 8'h00;
        bytes_if.end_of_stream = 1'b0;
        foreach (directed[i])
            stim.push_back(directed[i]);
        plan_random_text(104);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim.size() > 0)
        begin
            row = stim.pop_front();
            // switch between quiet stretches and stretches with idling
            if (n_requests % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = pick_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                bytes_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            bytes_if.valid         <= 1'b1;
            bytes_if.data_byte     <= row.data;
            bytes_if.end_of_stream <= row.eos;
            do
                @(posedge clk);
            while (!bytes_if.ready);

            // request taken: predict, or use the hand-written result for typed rows
            decode_byte(row.data, row.eos);
            if (row.typed)
            begin
                if (row.has_res)
                    awaited_cps.push_back('{row.cp, row.used, row.endm, 1'b1});
            end
            else
                foreach (step_out[i])
                    awaited_cps.push_back(step_out[i]);
            n_requests++;
        end
        @(negedge clk);
        bytes_if.valid <= 1'b0;

        // drain, then watch a little longer for stray results
        while (awaited_cps.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d byte requests sent, %0d results checked", n_requests, n_results);
        $display("%0d multi-byte code points, %0d code page fallbacks, %0d end markers",
                 n_multi, n_fallback, n_ends);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // result side: ready with random stalls, check in order
    // ---------------------------------------------------------------------

    initial
    begin
        int stall_left;
        int hold;
        stall_left   = 0;
        cps_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                cps_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                hold = pick_gap();
                cps_if.ready <= (hold == 0);
                if (hold > 0)
                    stall_left = hold - 1;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && cps_if.valid && cps_if.ready)
        begin
            if (awaited_cps.size() == 0)
            begin
                $display("%0t: unexpected result, code_point 0x%0h bytes_used %0d",
                         $time, cps_if.code_point, cps_if.bytes_used);
                errors++;
            end
            else
            begin
                want = awaited_cps.pop_front();
                check_field("code_point",  want.code_point,  cps_if.code_point);
                check_field("bytes_used",  want.bytes_used,  cps_if.bytes_used);
                check_field("end_marker",  want.end_marker,  cps_if.end_marker);
                check_field("last_of_run", want.last_of_run, cps_if.last_of_run);
                n_results++;
                if (want.end_marker)
                    n_ends++;
                else if (want.bytes_used > 3'd1)
                    n_multi++;
                else if (want.code_point >= 21'h80)
                    n_fallback++;
            end
        end
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/u8d_pkg.sv
sv/u8d_if.sv
sv/u8d_step.sv
sv/utf8_decoder_cp1252_fallback_core.sv
dv/utf8_decoder_cp1252_fallback_core_test.sv
